// ===== sv/gsp_pkg.sv =====
// Package for the generational slot pool: sizes, operation and status codes,
// the stored slot record type and the generation step function. No dependencies.
package gsp_pkg;

    localparam int SLOTS = 64;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int GW    = 31;

    localparam logic [GW-1:0] GEN_MAX = {GW{1'b1}};

    localparam logic [2:0] OP_SPAWN   = 3'd0;
    localparam logic [2:0] OP_RESERVE = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_COLLECT = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_ZERO   = 3'd2;
    localparam logic [2:0] ST_STALE  = 3'd3;
    localparam logic [2:0] ST_NOCOL  = 3'd4;
    localparam logic [2:0] ST_OTHER  = 3'd5;
    localparam logic [2:0] ST_NOTRES = 3'd6;

    typedef struct packed {
        logic [GW-1:0] gen;
        logic [15:0]   qty;
        logic [19:0]   gold;
        logic [19:0]   life;
        logic [7:0]    oid;
        logic [1:0]    otype;
        logic [SW-1:0] dpos;
    } t_slot;

    // Generation step: wraps from the maximum to 1 and never yields 0.
    function automatic logic [GW-1:0] next_gen(input logic [GW-1:0] g);
        logic [GW-1:0] n;
        n = (g == GEN_MAX) ? GW'(1) : g + GW'(1);
        return n;
    endfunction

endpackage

// ===== sv/gsp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gsp_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// ===== sv/generational_slot_pool_with_expiry_core.sv =====
// Top level of the generational slot pool with expiry.
// Depends on gsp_pkg and three instances of gsp_ram.
//
// Usage: an operation beat is taken at a rising edge where i_start is high
// and o_busy is low; all input fields are sampled at that edge. Exactly one
// result beat follows, shown for one cycle with o_valid high. The receiver
// cannot stall, so results are never held back or dropped.
// A rejected spawn or an unknown opcode answers straight from idle. A spawn
// pops the free stack, reads the slot record and writes it; reserve and release
// read the record and update it; a collect also frees the slot and swap-removes
// it from the dense list. A tick walks the dense live list, reading each entry
// and its slot record and freeing the expired ones. Every step of the walk goes
// in turn through the single read port of the slot record memory.
// Reset (synchronous, active low) empties the pool at once: per-entry valid
// bits make unwritten slot records read as zero and unwritten free stack
// entries read as their initial slot numbers, so no clearing pass is needed.
// A new operation may be taken in the same cycle its predecessor's result
// is shown.
module generational_slot_pool_with_expiry_core
    import gsp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  logic [2:0]    i_op,
    input  logic [5:0]    i_slot_index,
    input  logic [30:0]   i_handle_generation,
    input  logic [15:0]   i_quantity,
    input  logic [19:0]   i_gold_value,
    input  logic [19:0]   i_lifetime_ms,
    input  logic [7:0]    i_collector_id,
    input  logic [1:0]    i_collector_type,
    input  logic [15:0]   i_tick_delta_ms,
    output logic          o_valid,
    output logic [2:0]    o_status,
    output logic [5:0]    o_out_slot,
    output logic [30:0]   o_out_generation,
    output logic [15:0]   o_out_quantity,
    output logic [19:0]   o_out_gold,
    output logic [6:0]    o_expired_count,
    output logic [6:0]    o_live_count
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SP1  = 4'd1;
    localparam logic [3:0] S_SP2  = 4'd2;
    localparam logic [3:0] S_H1   = 4'd3;
    localparam logic [3:0] S_F0   = 4'd4;
    localparam logic [3:0] S_F1   = 4'd5;
    localparam logic [3:0] S_F2   = 4'd6;
    localparam logic [3:0] S_T0   = 4'd7;
    localparam logic [3:0] S_T1   = 4'd8;
    localparam logic [3:0] S_T2   = 4'd9;

    localparam int SLW = $bits(t_slot);

    logic [3:0]       r_state, n_state;
    logic [2:0]       r_op, n_op;
    logic [SW-1:0]    r_si, n_si;
    logic [GW-1:0]    r_hg, n_hg;
    logic [15:0]      r_qty, n_qty;
    logic [19:0]      r_gold, n_gold;
    logic [19:0]      r_life, n_life;
    logic [7:0]       r_cid, n_cid;
    logic [1:0]       r_ctype, n_ctype;
    logic [15:0]      r_delta, n_delta;
    logic [SLOTS-1:0] r_active, n_active;
    logic [SLOTS-1:0] r_resv, n_resv;
    logic [SLOTS-1:0] r_sv, n_sv;
    logic [SLOTS-1:0] r_fv, n_fv;
    logic [CW-1:0]    r_fc, n_fc;
    logic [CW-1:0]    r_live, n_live;
    logic [CW-1:0]    r_wpos, n_wpos;
    logic [SW-1:0]    r_s, n_s;
    logic [SW-1:0]    r_fpos, n_fpos;
    logic [GW-1:0]    r_gen, n_gen;
    logic [SW-1:0]    r_moved, n_moved;
    logic             r_ret_tick, n_ret_tick;
    logic             r_valid, n_valid;
    logic [2:0]       r_st, n_st;
    logic [SW-1:0]    r_os, n_os;
    logic [GW-1:0]    r_og, n_og;
    logic [15:0]      r_oq, n_oq;
    logic [19:0]      r_ogold, n_ogold;
    logic [CW-1:0]    r_exp, n_exp;
    logic             r_slot_rv;
    logic             r_fs_rv;
    logic [SW-1:0]    r_fs_ridx;

    // Memory ports.
    logic             sm_we;
    logic [SW-1:0]    sm_waddr, sm_raddr;
    t_slot            sm_wdata;
    logic [SLW-1:0]   sm_rdata;
    logic             dl_we;
    logic [SW-1:0]    dl_waddr, dl_raddr, dl_wdata, dl_rdata;
    logic             fs_we;
    logic [SW-1:0]    fs_waddr, fs_raddr, fs_wdata, fs_rdata;

    t_slot            e;
    logic [SW-1:0]    fs_q;
    logic             cur, match;
    logic [CW-1:0]    last;
    logic [19:0]      nl;
    logic [GW-1:0]    ng;

    // Slot records that were never written read as all zero.
    assign e    = r_slot_rv ? t_slot'(sm_rdata) : '0;
    assign fs_q = r_fs_rv ? fs_rdata : SW'(SLOTS - 1) - r_fs_ridx;

    assign cur   = r_active[r_si] && (e.gen == r_hg);
    assign match = r_resv[r_si] && (e.otype == r_ctype) && (e.oid != 8'd0) &&
                   (e.oid == r_cid);
    assign last  = r_live - CW'(1);
    assign nl    = (e.life > {4'd0, r_delta}) ? e.life - {4'd0, r_delta} : 20'd0;
    assign ng    = next_gen(e.gen);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_si       = r_si;
        n_hg       = r_hg;
        n_qty      = r_qty;
        n_gold     = r_gold;
        n_life     = r_life;
        n_cid      = r_cid;
        n_ctype    = r_ctype;
        n_delta    = r_delta;
        n_active   = r_active;
        n_resv     = r_resv;
        n_sv       = r_sv;
        n_fv       = r_fv;
        n_fc       = r_fc;
        n_live     = r_live;
        n_wpos     = r_wpos;
        n_s        = r_s;
        n_fpos     = r_fpos;
        n_gen      = r_gen;
        n_moved    = r_moved;
        n_ret_tick = r_ret_tick;
        n_valid    = 1'b0;
        n_st       = r_st;
        n_os       = r_os;
        n_og       = r_og;
        n_oq       = r_oq;
        n_ogold    = r_ogold;
        n_exp      = r_exp;
        sm_we      = 1'b0;
        sm_waddr   = '0;
        sm_wdata   = e;
        sm_raddr   = '0;
        dl_we      = 1'b0;
        dl_waddr   = '0;
        dl_wdata   = '0;
        dl_raddr   = '0;
        fs_we      = 1'b0;
        fs_waddr   = '0;
        fs_wdata   = '0;
        fs_raddr   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_op;
                    n_si    = i_slot_index;
                    n_hg    = i_handle_generation;
                    n_qty   = i_quantity;
                    n_gold  = i_gold_value;
                    n_life  = i_lifetime_ms;
                    n_cid   = i_collector_id;
                    n_ctype = i_collector_type;
                    n_delta = i_tick_delta_ms;
                    n_st    = ST_OK;
                    n_os    = '0;
                    n_og    = '0;
                    n_oq    = '0;
                    n_ogold = '0;
                    n_exp   = '0;
                    case (i_op)
                        OP_SPAWN: begin
                            if (r_fc == '0) begin
                                n_st    = ST_FULL;
                                n_valid = 1'b1;
                            end else if (i_quantity == 16'd0) begin
                                n_st    = ST_ZERO;
                                n_valid = 1'b1;
                            end else begin
                                n_fc     = r_fc - CW'(1);
                                fs_raddr = n_fc[SW-1:0];
                                n_state  = S_SP1;
                            end
                        end
                        OP_RESERVE, OP_RELEASE, OP_COLLECT: begin
                            sm_raddr = i_slot_index;
                            n_state  = S_H1;
                        end
                        OP_TICK: begin
                            n_wpos  = '0;
                            n_state = S_T0;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SP1: begin
                n_s      = fs_q;
                sm_raddr = fs_q;
                n_state  = S_SP2;
            end
            S_SP2: begin
                if (!r_active[r_s] && (r_live < CW'(SLOTS))) begin
                    sm_we          = 1'b1;
                    sm_waddr       = r_s;
                    sm_wdata.gen   = ng;
                    sm_wdata.qty   = r_qty;
                    sm_wdata.gold  = r_gold;
                    sm_wdata.life  = r_life;
                    sm_wdata.oid   = '0;
                    sm_wdata.otype = '0;
                    sm_wdata.dpos  = r_live[SW-1:0];
                    dl_we          = 1'b1;
                    dl_waddr       = r_live[SW-1:0];
                    dl_wdata       = r_s;
                    n_active[r_s]  = 1'b1;
                    n_resv[r_s]    = 1'b0;
                    n_live         = r_live + CW'(1);
                    n_os           = r_s;
                    n_og           = ng;
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_H1: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                if (!cur) begin
                    n_st = ST_STALE;
                end else begin
                    case (r_op)
                        OP_RESERVE: begin
                            if (r_cid == 8'd0) begin
                                n_st = ST_NOCOL;
                            end else if (r_resv[r_si] && !match) begin
                                n_st = ST_OTHER;
                            end else begin
                                sm_we          = 1'b1;
                                sm_waddr       = r_si;
                                sm_wdata.oid   = r_cid;
                                sm_wdata.otype = r_ctype;
                                n_resv[r_si]   = 1'b1;
                                n_os           = r_si;
                                n_og           = r_hg;
                                n_oq           = e.qty;
                                n_ogold        = e.gold;
                            end
                        end
                        OP_RELEASE: begin
                            if (!match) begin
                                n_st = ST_NOTRES;
                            end else begin
                                sm_we          = 1'b1;
                                sm_waddr       = r_si;
                                sm_wdata.oid   = '0;
                                sm_wdata.otype = '0;
                                n_resv[r_si]   = 1'b0;
                            end
                        end
                        OP_COLLECT: begin
                            if (!match) begin
                                n_st = ST_NOTRES;
                            end else begin
                                n_os       = r_si;
                                n_og       = r_hg;
                                n_oq       = e.qty;
                                n_ogold    = e.gold;
                                n_s        = r_si;
                                n_fpos     = e.dpos;
                                n_gen      = e.gen;
                                n_ret_tick = 1'b0;
                                n_valid    = 1'b0;
                                n_state    = S_F0;
                            end
                        end
                        default: begin
                            n_st = ST_OK;
                        end
                    endcase
                end
            end
            S_F0: begin
                // Clear the freed record but for its advanced generation, push it on the free
                // stack and start the swap-remove if it was not the last dense entry.
                sm_we         = 1'b1;
                sm_waddr      = r_s;
                sm_wdata      = '0;
                sm_wdata.gen  = next_gen(r_gen);
                n_active[r_s] = 1'b0;
                n_resv[r_s]   = 1'b0;
                if (r_fc < CW'(SLOTS)) begin
                    fs_we    = 1'b1;
                    fs_waddr = r_fc[SW-1:0];
                    fs_wdata = r_s;
                    n_fc     = r_fc + CW'(1);
                end
                n_live = last;
                if ({1'b0, r_fpos} != last) begin
                    dl_raddr = last[SW-1:0];
                    n_state  = S_F1;
                end else if (r_ret_tick) begin
                    n_state = S_T0;
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_F1: begin
                n_moved  = dl_rdata;
                dl_we    = 1'b1;
                dl_waddr = r_fpos;
                dl_wdata = dl_rdata;
                sm_raddr = dl_rdata;
                n_state  = S_F2;
            end
            S_F2: begin
                sm_we         = 1'b1;
                sm_waddr      = r_moved;
                sm_wdata.dpos = r_fpos;
                if (r_ret_tick) begin
                    n_state = S_T0;
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_T0: begin
                if (r_wpos >= r_live) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    dl_raddr = r_wpos[SW-1:0];
                    n_state  = S_T1;
                end
            end
            S_T1: begin
                n_s      = dl_rdata;
                sm_raddr = dl_rdata;
                n_state  = S_T2;
            end
            S_T2: begin
                n_state = S_T0;
                if (!r_active[r_s] || (e.life == 20'd0)) begin
                    n_wpos = r_wpos + CW'(1);
                end else if (nl == 20'd0) begin
                    // Expired: free it and revisit this dense position.
                    n_exp      = r_exp + CW'(1);
                    n_fpos     = e.dpos;
                    n_gen      = e.gen;
                    n_ret_tick = 1'b1;
                    n_state    = S_F0;
                end else begin
                    sm_we         = 1'b1;
                    sm_waddr      = r_s;
                    sm_wdata.life = nl;
                    n_wpos        = r_wpos + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (sm_we) begin
            n_sv[sm_waddr] = 1'b1;
        end
        if (fs_we) begin
            n_fv[fs_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_resv   <= '0;
            r_sv     <= '0;
            r_fv     <= '0;
            r_fc     <= CW'(SLOTS);
            r_live   <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_resv   <= n_resv;
            r_sv     <= n_sv;
            r_fv     <= n_fv;
            r_fc     <= n_fc;
            r_live   <= n_live;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_si       <= n_si;
        r_hg       <= n_hg;
        r_qty      <= n_qty;
        r_gold     <= n_gold;
        r_life     <= n_life;
        r_cid      <= n_cid;
        r_ctype    <= n_ctype;
        r_delta    <= n_delta;
        r_wpos     <= n_wpos;
        r_s        <= n_s;
        r_fpos     <= n_fpos;
        r_gen      <= n_gen;
        r_moved    <= n_moved;
        r_ret_tick <= n_ret_tick;
        r_st       <= n_st;
        r_os       <= n_os;
        r_og       <= n_og;
        r_oq       <= n_oq;
        r_ogold    <= n_ogold;
        r_exp      <= n_exp;
        r_slot_rv  <= r_sv[sm_raddr];
        r_fs_rv    <= r_fv[fs_raddr];
        r_fs_ridx  <= fs_raddr;
    end

    gsp_ram #(.W(SLW), .D(SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (sm_we),
        .i_waddr (sm_waddr),
        .i_wdata (sm_wdata),
        .i_raddr (sm_raddr),
        .o_rdata (sm_rdata)
    );

    gsp_ram #(.W(SW), .D(SLOTS)) u_dense_ram (
        .i_clk   (i_clk),
        .i_we    (dl_we),
        .i_waddr (dl_waddr),
        .i_wdata (dl_wdata),
        .i_raddr (dl_raddr),
        .o_rdata (dl_rdata)
    );

    gsp_ram #(.W(SW), .D(SLOTS)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (fs_wdata),
        .i_raddr (fs_raddr),
        .o_rdata (fs_rdata)
    );

    assign o_busy           = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_st;
    assign o_out_slot       = r_os;
    assign o_out_generation = r_og;
    assign o_out_quantity   = r_oq;
    assign o_out_gold       = r_ogold;
    assign o_expired_count  = r_exp;
    assign o_live_count     = r_live;

`ifndef NO_ASSERTIONS
    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (({1'b0, r_live} + {1'b0, r_fc}) == (CW+1)'(SLOTS)))
        else $error("live and free counts do not add up to the pool size");
    a_active_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_active) == 32'(r_live)))
        else $error("active bits disagree with the live count");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_valid)
        else $error("operation ended without a result beat");
    a_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_OK) && (r_op == OP_SPAWN)) |-> (o_out_generation != '0))
        else $error("spawned handle carries generation zero");
`endif
endmodule
